[hw/rtl/sntp_rv_pkg.sv]
// ----------------------------------------------------------------------------
// SNTP reply validator package
// Shared payload types, register indexes and status codes.
// ----------------------------------------------------------------------------
package sntp_rv_pkg;

	localparam int unsigned MsgBytes = 48;
	localparam int unsigned CntW     = 6;
	localparam int unsigned CfgIdxW  = 1;
	localparam int unsigned CfgDataW = 32;

	// register indexes of the configuration port
	localparam logic [CfgIdxW-1:0] REG_SENT_SECONDS  = 1'b0;
	localparam logic [CfgIdxW-1:0] REG_SENT_FRACTION = 1'b1;

	// status codes, in check order
	localparam logic [3:0] ST_OK         = 4'd0;
	localparam logic [3:0] ST_SHORT      = 4'd1;
	localparam logic [3:0] ST_MODE       = 4'd2;
	localparam logic [3:0] ST_VERSION    = 4'd3;
	localparam logic [3:0] ST_UNSYNC     = 4'd4;
	localparam logic [3:0] ST_REFUSED    = 4'd5;
	localparam logic [3:0] ST_STRAT_HIGH = 4'd6;
	localparam logic [3:0] ST_ORIG_BAD   = 4'd7;
	localparam logic [3:0] ST_ZERO_TIME  = 4'd8;

	// header fields
	localparam logic [2:0] MODE_SERVER  = 3'd4;
	localparam logic [1:0] LEAP_UNSYNC  = 2'd3;
	localparam logic [7:0] STRATUM_MAX  = 8'd15;
	localparam logic [13:0] MICRO_SCALE = 14'd15625;

	// byte positions inside the datagram
	localparam logic [CntW-1:0] POS_HEADER  = 6'd0;
	localparam logic [CntW-1:0] POS_STRATUM = 6'd1;
	localparam logic [CntW-1:0] POS_ORIG_LO = 6'd24;
	localparam logic [CntW-1:0] POS_ORIG_HI = 6'd31;
	localparam logic [CntW-1:0] POS_XMIT_LO = 6'd40;
	localparam logic [CntW-1:0] POS_XMIT_HI = 6'd47;
	localparam logic [CntW-1:0] POS_FULL    = CntW'(MsgBytes);

	typedef struct packed {
		logic [7:0] rx_byte;
		logic       last_byte;
	} rx_item_t;

	typedef struct packed {
		logic [3:0]  status;
		logic [7:0]  server_stratum;
		logic [31:0] transmit_seconds;
		logic [31:0] transmit_fraction;
		logic [19:0] transmit_micro;
	} result_t;

	// per-datagram capture state
	typedef struct packed {
		logic [CntW-1:0] byte_count;
		logic [7:0]      header_byte;
		logic [7:0]      stratum_byte;
		logic [63:0]     originate_stamp;
		logic [63:0]     transmit_stamp;
	} pkt_t;

endpackage

[hw/rtl/sntp_reply_validator_top.sv]
// ----------------------------------------------------------------------------
// SNTP reply validator top level
// Grades one received SNTP reply, taken a byte per transaction.
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  in      | to block  | in_valid/in_stall   | in_data  (rx_byte, last_byte)
//  out     | from block| out_valid/out_stall | out_data (status .. transmit_micro)
//  cfg     | to block  | cfg_we              | cfg_index, cfg_wdata
//
//  One byte is taken every cycle unless the input is stalled; a byte is held in the input register,
//  and the result of a final byte is loaded into the output register as that byte leaves it.
//  The output register stalls the input only while it holds an untaken result
//  and the input register holds another final byte.
//  Reset clears the valid bits, the capture state and both sent-time registers.
// ----------------------------------------------------------------------------
module sntp_reply_validator_top (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  sntp_rv_pkg::rx_item_t                 in_data,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output sntp_rv_pkg::result_t                  out_data,
	input  logic                                  cfg_we,
	input  logic [sntp_rv_pkg::CfgIdxW-1:0]       cfg_index,
	input  logic [sntp_rv_pkg::CfgDataW-1:0]      cfg_wdata
);
	import sntp_rv_pkg::*;

	logic     valid_s1;
	rx_item_t item_s1;
	logic     adv;
	pkt_t     nxt;
	result_t  res;
	result_t  res_q;
	logic     res_valid_q;
	logic [31:0] sent_seconds_q;
	logic [31:0] sent_fraction_q;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sent_seconds_q  <= '0;
			sent_fraction_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SENT_SECONDS:  sent_seconds_q  <= cfg_wdata;
				REG_SENT_FRACTION: sent_fraction_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// a byte leaves the input register unless its result has nowhere to go
	assign adv      = valid_s1 && (!item_s1.last_byte || !res_valid_q || !out_stall);
	assign in_stall = valid_s1 && !adv;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall) begin
			item_s1 <= in_data;
		end
	end

	sntp_rv_capture u_capture (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.item   (item_s1),
		.nxt    (nxt)
	);

	sntp_rv_grade u_grade (
		.pkt           (nxt),
		.sent_seconds  (sent_seconds_q),
		.sent_fraction (sent_fraction_q),
		.res           (res)
	);

	// result register: load on a final byte, drop once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (adv && item_s1.last_byte) begin
			res_valid_q <= 1'b1;
		end else if (!out_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && item_s1.last_byte) begin
			res_q <= res;
		end
	end

	assign out_valid = res_valid_q;
	assign out_data  = res_q;

`ifndef SYNTHESIS
	a_stall_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && item_s1.last_byte && res_valid_q)
		else $error("input stalled without a blocked final byte");

	a_last_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		adv && item_s1.last_byte |=> out_valid)
		else $error("final byte produced no result");

	a_clear_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		adv && item_s1.last_byte |=> nxt.byte_count <= 6'd1)
		else $error("capture state not cleared after final byte");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		nxt.byte_count <= POS_FULL)
		else $error("byte count past datagram size");
`endif

endmodule

[hw/rtl/sntp_rv_capture.sv]
// ----------------------------------------------------------------------------
// SNTP reply validator: field capture
// Counts datagram bytes and captures header, stratum and both timestamps.
// ----------------------------------------------------------------------------
module sntp_rv_capture (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  adv,
	input  sntp_rv_pkg::rx_item_t item,
	output sntp_rv_pkg::pkt_t     nxt
);
	import sntp_rv_pkg::*;

	pkt_t pkt_q;

	// fold the current byte into the captured fields
	always_comb begin
		nxt = pkt_q;
		if (pkt_q.byte_count < POS_FULL) begin
			if (pkt_q.byte_count == POS_HEADER) begin
				nxt.header_byte = item.rx_byte;
			end else if (pkt_q.byte_count == POS_STRATUM) begin
				nxt.stratum_byte = item.rx_byte;
			end else if (pkt_q.byte_count inside {[POS_ORIG_LO:POS_ORIG_HI]}) begin
				nxt.originate_stamp = {pkt_q.originate_stamp[55:0], item.rx_byte};
			end else if (pkt_q.byte_count inside {[POS_XMIT_LO:POS_XMIT_HI]}) begin
				nxt.transmit_stamp = {pkt_q.transmit_stamp[55:0], item.rx_byte};
			end
			nxt.byte_count = pkt_q.byte_count + 1'b1;
		end
	end

	// advance the state; clear it after the final byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pkt_q <= '0;
		end else if (adv) begin
			if (item.last_byte) begin
				pkt_q <= '0;
			end else begin
				pkt_q <= nxt;
			end
		end
	end

endmodule

[hw/rtl/sntp_rv_grade.sv]
// ----------------------------------------------------------------------------
// SNTP reply validator: grading
// Checks a completed reply in priority order and forms the result fields.
// ----------------------------------------------------------------------------
module sntp_rv_grade (
	input  sntp_rv_pkg::pkt_t    pkt,
	input  logic [31:0]          sent_seconds,
	input  logic [31:0]          sent_fraction,
	output sntp_rv_pkg::result_t res
);
	import sntp_rv_pkg::*;

	logic [1:0]  leap;
	logic [2:0]  ver;
	logic [2:0]  mode;
	logic [3:0]  status;
	logic [29:0] micro_prod;

	assign leap = pkt.header_byte[7:6];
	assign ver  = pkt.header_byte[5:3];
	assign mode = pkt.header_byte[2:0];

	// pick the first failing check
	always_comb begin
		if (pkt.byte_count < POS_FULL) begin
			status = ST_SHORT;
		end else if (mode != MODE_SERVER) begin
			status = ST_MODE;
		end else if (!(ver inside {[3'd1:3'd4]})) begin
			status = ST_VERSION;
		end else if (leap == LEAP_UNSYNC) begin
			status = ST_UNSYNC;
		end else if (pkt.stratum_byte == 8'd0) begin
			status = ST_REFUSED;
		end else if (pkt.stratum_byte > STRATUM_MAX) begin
			status = ST_STRAT_HIGH;
		end else if (pkt.originate_stamp != {sent_seconds, sent_fraction}) begin
			status = ST_ORIG_BAD;
		end else if (pkt.transmit_stamp[63:32] == 32'd0) begin
			status = ST_ZERO_TIME;
		end else begin
			status = ST_OK;
		end
	end

	// upper fraction bits scaled to microseconds
	assign micro_prod = 30'(pkt.transmit_stamp[31:16]) * 30'(MICRO_SCALE);

	// drive the result; timestamps only for a good or zero-time reply
	always_comb begin
		res                = '0;
		res.status         = status;
		res.server_stratum = (status == ST_SHORT) ? 8'd0 : pkt.stratum_byte;
		if (status == ST_OK || status == ST_ZERO_TIME) begin
			res.transmit_seconds  = pkt.transmit_stamp[63:32];
			res.transmit_fraction = pkt.transmit_stamp[31:0];
			res.transmit_micro    = micro_prod[29:10];
		end
	end

endmodule
